/* sv/vkd_pkg.sv */
// ----------------------------------------------------------------------------
// vkd_pkg
// Shared types and constants of the vertex key de-duplication indexer: field
// widths, hash constants, response status codes, controller states, datapath
// operations and the status group returned by the datapath.
// ----------------------------------------------------------------------------
package vkd_pkg;

   // default table geometry
   localparam int DEF_TABLE_ENTRIES = 4096;
   localparam int DEF_INDEX_BITS    = 16;

   // stream field widths
   localparam int FIELD_W    = 16;
   localparam int VERTEX_W   = 12;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_USER_W = 3;
   localparam int RSP_PAD_W  = RSP_DATA_W - VERTEX_W - 3 * FIELD_W;

   // multiplicative hash with an xor-shift fold
   localparam int          HASH_W     = 64;
   localparam int          HALF_W     = HASH_W / 2;
   localparam logic [63:0] HASH_MULT  = 64'h9E37_79B9_7F4A_7C15;
   localparam int          HASH_SHIFT = 29;

   // remainder for table sizes that are not a power of two: four folds of the
   // upper half, a reciprocal estimate, then subtract and correct
   localparam int MOD_STEPS = 6;
   localparam int MOD_CNT_W = $clog2(MOD_STEPS);

   // response status codes
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_CLEARED = 2'd2
   } status_type;

   // controller states
   typedef enum logic [3:0] {
      ST_INIT_SWEEP,
      ST_IDLE,
      ST_CLR_SWEEP,
      ST_CLR_RSP,
      ST_MUL_LO,
      ST_MUL_CROSS_A,
      ST_MUL_CROSS_B,
      ST_MIX,
      ST_MOD,
      ST_READ,
      ST_EVAL
   } ctrl_state_type;

   // datapath operations, one per cycle
   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_MUL_LO,
      OP_MUL_CROSS_A,
      OP_MUL_CROSS_B,
      OP_MIX,
      OP_MOD,
      OP_READ,
      OP_NEXT,
      OP_INSERT,
      OP_RSP_HIT,
      OP_RSP_FULL,
      OP_RSP_CLEAR,
      OP_SWEEP
   } dp_op_type;

   // datapath status toward the controller
   typedef struct packed {
      logic need_mod;
      logic mod_last;
      logic sweep_last;
      logic slot_valid;
      logic key_match;
      logic table_full;
      logic probe_last;
      logic rsp_busy;
   } dp_status_type;

endpackage

/* sv/vkd_ctrl.sv */
// ----------------------------------------------------------------------------
// vkd_ctrl
// Controller of the indexer: sequences the clearing sweep, the multi-cycle
// hash and the linear probe loop, and issues one datapath operation a cycle.
// ----------------------------------------------------------------------------
module vkd_ctrl
   import vkd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_clear,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_op_type     op
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT_SWEEP: begin
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = req_clear ? ST_CLR_SWEEP : ST_MUL_LO;
            end
         end
         ST_CLR_SWEEP: begin
            if (status.sweep_last) state_in = ST_CLR_RSP;
         end
         ST_CLR_RSP: begin
            if (!status.rsp_busy) state_in = ST_IDLE;
         end
         ST_MUL_LO:      state_in = ST_MUL_CROSS_A;
         ST_MUL_CROSS_A: state_in = ST_MUL_CROSS_B;
         ST_MUL_CROSS_B: state_in = ST_MIX;
         ST_MIX: begin
            state_in = status.need_mod ? ST_MOD : ST_READ;
         end
         ST_MOD: begin
            if (status.mod_last) state_in = ST_READ;
         end
         ST_READ: state_in = ST_EVAL;
         ST_EVAL: begin
            if (status.slot_valid && !status.key_match && !status.probe_last) begin
               state_in = ST_EVAL;
            end else if (!status.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT_SWEEP;
      endcase
   end

   // outputs
   always_comb begin
      op         = OP_IDLE;
      req_tready = 1'b0;
      case (state_ff)
         ST_INIT_SWEEP: op = OP_SWEEP;
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) op = OP_LOAD;
         end
         ST_CLR_SWEEP: op = OP_SWEEP;
         ST_CLR_RSP: begin
            if (!status.rsp_busy) op = OP_RSP_CLEAR;
         end
         ST_MUL_LO:      op = OP_MUL_LO;
         ST_MUL_CROSS_A: op = OP_MUL_CROSS_A;
         ST_MUL_CROSS_B: op = OP_MUL_CROSS_B;
         ST_MIX:         op = OP_MIX;
         ST_MOD:         op = OP_MOD;
         ST_READ:        op = OP_READ;
         ST_EVAL: begin
            // occupied slot with another key: step on without waiting for output
            if (status.slot_valid && !status.key_match && !status.probe_last) begin
               op = OP_NEXT;
            end else if (!status.rsp_busy) begin
               if (!status.slot_valid) begin
                  op = status.table_full ? OP_RSP_FULL : OP_INSERT;
               end else if (status.key_match) begin
                  op = OP_RSP_HIT;
               end else begin
                  op = OP_RSP_FULL;
               end
            end
         end
         default: op = OP_IDLE;
      endcase
   end

endmodule

/* sv/vkd_dpath.sv */
// ----------------------------------------------------------------------------
// vkd_dpath
// Datapath of the indexer: key registers, shared 32x32 hash multiplier,
// folded remainder by reciprocal multiplication, single-port table memory with
// registered read, probe counters, vertex counter and the response register.
// ----------------------------------------------------------------------------
module vkd_dpath
   import vkd_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
   parameter int INDEX_BITS    = DEF_INDEX_BITS
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  dp_op_type             op,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output dp_status_type         status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   localparam int SLOT_W  = $clog2(TABLE_ENTRIES);
   localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
   localparam int KEY_W   = 3 * INDEX_BITS;
   localparam int ENTRY_W = 1 + KEY_W + SLOT_W;
   localparam bit IS_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);

   localparam logic [SLOT_W-1:0]    LAST_SLOT  = SLOT_W'(TABLE_ENTRIES - 1);
   localparam logic [CNT_W-1:0]     TABLE_SIZE = CNT_W'(TABLE_ENTRIES);
   localparam logic [HALF_W-1:0]    MOD_CONST  = HALF_W'(TABLE_ENTRIES);
   localparam logic [HALF_W-1:0]    MOD_FOLD   = HALF_W'((64'd1 << HALF_W) % TABLE_ENTRIES);
   localparam logic [HALF_W-1:0]    MOD_RECIP  = HALF_W'((64'd1 << HALF_W) / TABLE_ENTRIES);
   localparam logic [MOD_CNT_W-1:0] MOD_RECIP_STEP = MOD_CNT_W'(MOD_STEPS - 2);
   localparam logic [MOD_CNT_W-1:0] MOD_LAST   = MOD_CNT_W'(MOD_STEPS - 1);

   // key registers
   logic [INDEX_BITS-1:0] pos_ff, pos_in;
   logic [INDEX_BITS-1:0] nrm_ff, nrm_in;
   logic [INDEX_BITS-1:0] uv_ff, uv_in;
   logic [KEY_W-1:0]      key;
   logic [HASH_W-1:0]     key_wide;

   // hash state
   logic [HASH_W-1:0]    acc_ff, acc_in;
   logic [HASH_W-1:0]    hash_ff, hash_in;
   logic [MOD_CNT_W-1:0] mod_cnt_ff, mod_cnt_in;
   logic [HALF_W-1:0]    mul_a, mul_b;
   logic [HASH_W-1:0]    prod;
   logic [HASH_W-1:0]    mix;
   logic [HASH_W-1:0]    fold_sum;
   logic [HALF_W-1:0]    rem_est;
   logic [HALF_W-1:0]    rem_fix;

   // probe and table state
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [SLOT_W-1:0]  slot_next;
   logic [SLOT_W-1:0]  probe_ff, probe_in;
   logic [SLOT_W-1:0]  sweep_ff, sweep_in;
   logic [CNT_W-1:0]   unique_ff, unique_in;
   logic [ENTRY_W-1:0] tbl_mem [TABLE_ENTRIES];
   logic [ENTRY_W-1:0] rd_ff;
   logic               mem_we;
   logic [SLOT_W-1:0]  mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic               mem_re;
   logic [SLOT_W-1:0]  mem_raddr;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VERTEX_W-1:0] rsp_vertex_ff, rsp_vertex_in;
   logic                rsp_new_ff, rsp_new_in;
   logic [FIELD_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [FIELD_W-1:0]  rsp_nrm_ff, rsp_nrm_in;
   logic [FIELD_W-1:0]  rsp_uv_ff, rsp_uv_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic                rsp_load;
   logic                rsp_busy;

   assign key      = {uv_ff, nrm_ff, pos_ff};
   assign key_wide = HASH_W'(key);

   // key capture on an accepted transfer
   always_comb begin
      pos_in = pos_ff;
      nrm_in = nrm_ff;
      uv_in  = uv_ff;
      if (op == OP_LOAD) begin
         pos_in = INDEX_BITS'(req_tdata[FIELD_W-1:0]);
         nrm_in = INDEX_BITS'(req_tdata[2*FIELD_W-1:FIELD_W]);
         uv_in  = INDEX_BITS'(req_tdata[3*FIELD_W-1:2*FIELD_W]);
      end
   end

   // shared multiplier: hash partial products, then the remainder steps
   always_comb begin
      case (op)
         OP_MUL_LO: begin
            mul_a = key_wide[HALF_W-1:0];
            mul_b = HASH_MULT[HALF_W-1:0];
         end
         OP_MUL_CROSS_A: begin
            mul_a = key_wide[HALF_W-1:0];
            mul_b = HASH_MULT[HASH_W-1:HALF_W];
         end
         OP_MOD: begin
            if (mod_cnt_ff < MOD_RECIP_STEP) begin
               mul_a = hash_ff[HASH_W-1:HALF_W];
               mul_b = MOD_FOLD;
            end else if (mod_cnt_ff == MOD_RECIP_STEP) begin
               mul_a = hash_ff[HALF_W-1:0];
               mul_b = MOD_RECIP;
            end else begin
               mul_a = hash_ff[HASH_W-1:HALF_W];
               mul_b = MOD_CONST;
            end
         end
         default: begin
            mul_a = key_wide[HASH_W-1:HALF_W];
            mul_b = HASH_MULT[HALF_W-1:0];
         end
      endcase
   end

   assign prod = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
   assign mix  = acc_ff ^ (acc_ff >> HASH_SHIFT);

   // accumulate partial products
   always_comb begin
      acc_in = acc_ff;
      case (op)
         OP_MUL_LO:      acc_in = prod;
         OP_MUL_CROSS_A: acc_in = acc_ff + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
         OP_MUL_CROSS_B: acc_in = acc_ff + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
         default:        acc_in = acc_ff;
      endcase
   end

   // remainder: fold the upper half by 2^32 mod size, estimate the quotient
   // from the reciprocal, subtract and correct once
   assign fold_sum = prod + {{HALF_W{1'b0}}, hash_ff[HALF_W-1:0]};
   assign rem_est  = hash_ff[HALF_W-1:0] - prod[HALF_W-1:0];
   assign rem_fix  = (rem_est >= MOD_CONST) ? rem_est - MOD_CONST : rem_est;

   assign slot_next = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;

   // hash fold, remainder and probe registers
   always_comb begin
      hash_in    = hash_ff;
      mod_cnt_in = mod_cnt_ff;
      slot_in    = slot_ff;
      probe_in   = probe_ff;
      case (op)
         OP_MIX: begin
            hash_in    = mix;
            mod_cnt_in = '0;
            slot_in    = mix[SLOT_W-1:0];
            probe_in   = '0;
         end
         OP_MOD: begin
            mod_cnt_in = mod_cnt_ff + 1'b1;
            if (mod_cnt_ff < MOD_RECIP_STEP) begin
               hash_in = fold_sum;
            end else if (mod_cnt_ff == MOD_RECIP_STEP) begin
               // quotient estimate in the upper half, folded value kept below
               hash_in = {prod[HASH_W-1:HALF_W], hash_ff[HALF_W-1:0]};
            end else begin
               slot_in = rem_fix[SLOT_W-1:0];
            end
         end
         OP_NEXT: begin
            slot_in  = slot_next;
            probe_in = probe_ff + 1'b1;
         end
         default: begin
            hash_in = hash_ff;
         end
      endcase
   end

   // sweep address and vertex counter
   always_comb begin
      sweep_in  = sweep_ff;
      unique_in = unique_ff;
      case (op)
         OP_SWEEP: begin
            sweep_in  = (sweep_ff == LAST_SLOT) ? '0 : sweep_ff + 1'b1;
            unique_in = '0;
         end
         OP_INSERT: unique_in = unique_ff + 1'b1;
         default:   unique_in = unique_ff;
      endcase
   end

   // table port control
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = slot_ff;
      mem_wdata = {1'b1, key, unique_ff[SLOT_W-1:0]};
      mem_re    = 1'b0;
      mem_raddr = slot_ff;
      case (op)
         OP_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = '0;
         end
         OP_INSERT: mem_we = 1'b1;
         OP_READ:   mem_re = 1'b1;
         OP_NEXT: begin
            mem_re    = 1'b1;
            mem_raddr = slot_next;
         end
         default: mem_re = 1'b0;
      endcase
   end

   // table memory write
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tbl_mem[mem_waddr] <= mem_wdata;
      end
   end

   // table memory read, data registered
   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_ff <= tbl_mem[mem_raddr];
      end
   end

   // response register contents
   assign rsp_busy = rsp_valid_ff && !rsp_tready;

   always_comb begin
      rsp_load      = 1'b1;
      rsp_vertex_in = '0;
      rsp_new_in    = 1'b0;
      rsp_pos_in    = '0;
      rsp_nrm_in    = '0;
      rsp_uv_in     = '0;
      rsp_status_in = STATUS_OK;
      case (op)
         OP_INSERT: begin
            rsp_vertex_in = VERTEX_W'(unique_ff[SLOT_W-1:0]);
            rsp_new_in    = 1'b1;
            rsp_pos_in    = FIELD_W'(pos_ff);
            rsp_nrm_in    = FIELD_W'(nrm_ff);
            rsp_uv_in     = FIELD_W'(uv_ff);
         end
         OP_RSP_HIT:   rsp_vertex_in = VERTEX_W'(rd_ff[SLOT_W-1:0]);
         OP_RSP_FULL:  rsp_status_in = STATUS_FULL;
         OP_RSP_CLEAR: rsp_status_in = STATUS_CLEARED;
         default:      rsp_load = 1'b0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         unique_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sweep_ff     <= sweep_in;
         unique_ff    <= unique_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      nrm_ff     <= nrm_in;
      uv_ff      <= uv_in;
      acc_ff     <= acc_in;
      hash_ff    <= hash_in;
      mod_cnt_ff <= mod_cnt_in;
      slot_ff    <= slot_in;
      probe_ff   <= probe_in;
      if (rsp_load) begin
         rsp_vertex_ff <= rsp_vertex_in;
         rsp_new_ff    <= rsp_new_in;
         rsp_pos_ff    <= rsp_pos_in;
         rsp_nrm_ff    <= rsp_nrm_in;
         rsp_uv_ff     <= rsp_uv_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   // status toward the controller
   always_comb begin
      status.need_mod   = !IS_POW2;
      status.mod_last   = (mod_cnt_ff == MOD_LAST);
      status.sweep_last = (sweep_ff == LAST_SLOT);
      status.slot_valid = rd_ff[ENTRY_W-1];
      status.key_match  = (rd_ff[KEY_W+SLOT_W-1:SLOT_W] == key);
      status.table_full = (unique_ff == TABLE_SIZE);
      status.probe_last = (probe_ff == LAST_SLOT);
      status.rsp_busy   = rsp_busy;
   end

   // result stream
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_uv_ff, rsp_nrm_ff, rsp_pos_ff, rsp_vertex_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_new_ff};

endmodule

/* sv/vertex_key_dedup_indexer_unit.sv */
// ----------------------------------------------------------------------------
// vertex_key_dedup_indexer_unit
// Vertex de-duplication for index buffer building: maps each face-corner
// index triple to a dense vertex number in first-seen order.
// ----------------------------------------------------------------------------
// After reset the unit runs a clearing pass over its whole hash table before
// it takes the first transfer; a clear command runs the same pass and then
// returns one response with status cleared. A lookup that the first probe
// settles runs from acceptance through the low and the two cross partial
// products on the shared 32x32 multiplier for the 64-bit hash, a fold
// step, then a read and a compare on the single-port table memory, until the
// unit is ready again. Each further probe of a collision chain is one more
// compare, with the next read overlapping it, and a table size that is not a
// power of two adds the remainder steps after the fold. A finished response
// waits in the output register, so a new request is taken while it is
// pending. The table holds TABLE_ENTRIES triples; a new triple that finds the
// table full is reported with status full and is not stored.
// ----------------------------------------------------------------------------
module vertex_key_dedup_indexer_unit
   import vkd_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
   parameter int INDEX_BITS    = DEF_INDEX_BITS
)
(
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // position_index, normal_index, uv_index
   input  logic                  req_tuser,  // cmd
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // vertex_index, new_position_index,
                                             // new_normal_index, new_uv_index, zero pad
   output logic [RSP_USER_W-1:0] rsp_tuser   // is_new, status
);

   dp_op_type     op;
   dp_status_type status;

   // sequencing
   vkd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_clear  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .op         (op)
   );

   // table, hash and response datapath
   vkd_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .INDEX_BITS    (INDEX_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .req_tdata  (req_tdata),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
